// File: src/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// shared word type, saturation helper and scheme / register codes for the
// triangle residual distribution core
// ----------------------------------------------------------------------------
package trd_pkg;

	localparam int WORD_W        = 32;
	localparam int FRAC_BITS_DEF = 16;

	typedef logic [WORD_W-1:0] word_t;

	// distribution scheme select
	typedef enum logic [1:0] {
		SCH_N     = 2'd0,
		SCH_LDA   = 2'd1,
		SCH_BLEND = 2'd2,
		SCH_LIMN  = 2'd3
	} scheme_t;

	// configuration register indexes
	localparam logic [1:0] REG_ADVECT_X = 2'd0;
	localparam logic [1:0] REG_ADVECT_Y = 2'd1;
	localparam logic [1:0] REG_SCHEME   = 2'd2;

	localparam word_t WORD_MAX = 32'h7fff_ffff;
	localparam word_t WORD_MIN = 32'h8000_0000;

	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

	// saturated word plus overflow flag
	typedef struct packed {
		logic  f;
		word_t w;
	} sat_t;

	// clamp a wide signed value into one word
	function automatic sat_t sat_w(input logic signed [65:0] x);
		sat_t r;
		if (x > SAT_HI) begin
			r.f = 1'b1;
			r.w = WORD_MAX;
		end else if (x < SAT_LO) begin
			r.f = 1'b1;
			r.w = WORD_MIN;
		end else begin
			r.f = 1'b0;
			r.w = x[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: src/trd_div.sv
// ----------------------------------------------------------------------------
// trd_div
// pipelined restoring divider: (num * 2^FRAC_BITS) / den, truncated toward
// zero and saturated to one word, one quotient bit per stage
// ----------------------------------------------------------------------------
module trd_div #(
	parameter int FRAC_BITS = trd_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  trd_pkg::word_t      num,
	input  trd_pkg::word_t      den,
	output trd_pkg::word_t      quo,
	output logic                ovf
);

	localparam int W   = trd_pkg::WORD_W;
	localparam int N_W = W + FRAC_BITS;

	localparam logic [N_W-1:0] Q_POS_MAX = N_W'(32'h7fff_ffff);
	localparam logic [N_W-1:0] Q_NEG_MAX = N_W'(32'h8000_0000);

	logic [W:0] num_ext, den_ext, num_mag, den_mag;

	logic [W-1:0]   rem_q [0:N_W];
	logic [N_W-1:0] dvd_q [0:N_W];
	logic [N_W-1:0] quo_q [0:N_W];
	logic [W-1:0]   dsr_q [0:N_W];
	logic           neg_q [0:N_W];

	// magnitudes of the operands
	assign num_ext = (W+1)'($signed(num));
	assign den_ext = (W+1)'($signed(den));
	assign num_mag = num[W-1] ? (W+1)'(0) - num_ext : num_ext;
	assign den_mag = den[W-1] ? (W+1)'(0) - den_ext : den_ext;

	// input stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= '0;
			dvd_q[0] <= {num_mag[W-1:0], {FRAC_BITS{1'b0}}};
			quo_q[0] <= '0;
			dsr_q[0] <= den_mag[W-1:0];
			neg_q[0] <= num[W-1] ^ den[W-1];
		end
	end

	// one quotient bit per stage
	for (genvar j = 1; j <= N_W; j++) begin : g_step
		logic [W:0] trial;
		logic       ge;
		assign trial = {rem_q[j-1], dvd_q[j-1][N_W-1]};
		assign ge    = trial >= {1'b0, dsr_q[j-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= ge ? W'(trial - {1'b0, dsr_q[j-1]}) : trial[W-1:0];
				dvd_q[j] <= {dvd_q[j-1][N_W-2:0], 1'b0};
				quo_q[j] <= {quo_q[j-1][N_W-2:0], ge};
				dsr_q[j] <= dsr_q[j-1];
				neg_q[j] <= neg_q[j-1];
			end
		end
	end

	// sign and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_q[N_W]) begin
				if (quo_q[N_W] > Q_NEG_MAX) begin
					quo <= trd_pkg::WORD_MIN;
					ovf <= 1'b1;
				end else begin
					quo <= W'(0) - quo_q[N_W][W-1:0];
					ovf <= 1'b0;
				end
			end else begin
				if (quo_q[N_W] > Q_POS_MAX) begin
					quo <= trd_pkg::WORD_MAX;
					ovf <= 1'b1;
				end else begin
					quo <= quo_q[N_W][W-1:0];
					ovf <= 1'b0;
				end
			end
		end
	end

endmodule

// File: src/triangle_residual_distribution_core.sv
// ----------------------------------------------------------------------------
// triangle_residual_distribution_core
// per-triangle residual distribution (N, LDA, blended, limited N) for 2D
// linear advection in saturating signed fixed point
// ----------------------------------------------------------------------------
// Accepts one triangle per clock while the skid entry is empty and returns
// one request of three nodal shares plus a saturation flag per triangle, in
// order. Between input acceptance and the output register lie three chained
// groups of restoring dividers that resolve one quotient bit per stage. An
// output register with a one-entry skid stage lets the pipeline take one
// more triangle while a result waits; the user must write advect_x, advect_y
// and scheme_mode only while idle, which the block itself does not enforce.
module triangle_residual_distribution_core #(
	parameter int FRAC_BITS = trd_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, value0, value1, value2
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// share0, share1, share2
	output logic [95:0]  m_tdata,
	// saturated
	output logic [0:0]   m_tuser
);

	localparam int W       = trd_pkg::WORD_W;
	localparam int DIV_LAT = W + FRAC_BITS + 2;

	localparam trd_pkg::word_t ONE_W = trd_pkg::word_t'(1) << FRAC_BITS;

	typedef logic [2:0][W-1:0]   w3_t;
	typedef logic [2:0][2*W-1:0] p3_t;

	typedef struct packed {
		trd_pkg::scheme_t mode;
		logic             act;
		logic             sat;
		w3_t              v;
		w3_t              x;
		w3_t              y;
		w3_t              kp;
		w3_t              km;
		w3_t              tm;
		w3_t              lda;
		w3_t              w;
		w3_t              nsh;
		w3_t              absn;
		w3_t              bp;
		w3_t              nb;
		w3_t              f0;
		w3_t              f1;
		w3_t              d;
		p3_t              pr0;
		p3_t              pr1;
		trd_pkg::word_t   kpsum;
		trd_pkg::word_t   fi;
		trd_pkg::word_t   s;
		trd_pkg::word_t   absfi;
		trd_pkg::word_t   acc;
		trd_pkg::word_t   theta;
		trd_pkg::word_t   omt;
		trd_pkg::word_t   bsum;
		trd_pkg::word_t   accb;
	} item_t;

	typedef struct packed {
		logic act;
		logic sat;
		w3_t  d;
	} res_t;

	// helpers
	function automatic logic signed [65:0] ext(input trd_pkg::word_t a);
		return 66'($signed(a));
	endfunction

	function automatic logic [2*W-1:0] mul_w(input trd_pkg::word_t a, input trd_pkg::word_t b);
		logic signed [2*W-1:0] r;
		r = $signed(a) * $signed(b);
		return r;
	endfunction

	function automatic trd_pkg::sat_t fmul_w(input logic [2*W-1:0] p);
		logic signed [2*W-1:0] s;
		s = $signed(p) >>> FRAC_BITS;
		return trd_pkg::sat_w(66'(s));
	endfunction

	function automatic trd_pkg::sat_t abs_w(input trd_pkg::word_t a);
		return trd_pkg::sat_w(a[W-1] ? 66'sd0 - ext(a) : ext(a));
	endfunction

	// configuration registers
	trd_pkg::word_t   advect_x_q, advect_y_q;
	trd_pkg::scheme_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			advect_x_q <= '0;
			advect_y_q <= '0;
			mode_q     <= trd_pkg::SCH_N;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				trd_pkg::REG_ADVECT_X: advect_x_q <= cfg_wdata;
				trd_pkg::REG_ADVECT_Y: advect_y_q <= cfg_wdata;
				trd_pkg::REG_SCHEME:   mode_q <= trd_pkg::scheme_t'(cfg_wdata[1:0]);
				default: ;
			endcase
		end
	end

	// pipeline enable: held only while the skid entry is occupied
	logic en;
	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	item_t it_s7, it_s8, it_s9, it_s10, it_s11, it_s12;
	item_t it_s13, it_s14, it_s15, it_s16, it_s17;
	res_t  it_s18;
	item_t n_s1, n_s2, n_s3, n_s4, n_s5, n_s6;
	item_t n_s7, n_s8, n_s9, n_s10, n_s11, n_s12;
	item_t n_s13, n_s14, n_s15, n_s16, n_s17;
	res_t  n_s18;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18;

	item_t            dla_q [DIV_LAT];
	item_t            dlb_q [DIV_LAT];
	item_t            dlc_q [DIV_LAT];
	logic [DIV_LAT-1:0] vla_q, vlb_q, vlc_q;

	w3_t            qs, ql, qb, qc;
	logic [2:0]     os, ol, ob, oc;
	trd_pkg::word_t qt;
	logic           ot;

	// stage 1: inward edge normals
	always_comb begin
		trd_pkg::sat_t r;
		w3_t px, py;
		int a, b;
		n_s1      = '0;
		n_s1.mode = mode_q;
		for (int i = 0; i < 3; i++) begin
			px[i]     = s_tdata[64*i +: 32];
			py[i]     = s_tdata[64*i+32 +: 32];
			n_s1.v[i] = s_tdata[192+32*i +: 32];
		end
		for (int i = 0; i < 3; i++) begin
			a = (i == 0) ? 2 : i - 1;
			b = (i == 2) ? 0 : i + 1;
			r = trd_pkg::sat_w(ext(py[b]) - ext(py[a]));
			n_s1.x[i] = r.w;
			n_s1.sat  = n_s1.sat | r.f;
			r = trd_pkg::sat_w(ext(px[a]) - ext(px[b]));
			n_s1.y[i] = r.w;
			n_s1.sat  = n_s1.sat | r.f;
		end
	end

	// stage 2: advection times normal products
	always_comb begin
		n_s2 = it_s1;
		for (int i = 0; i < 3; i++) begin
			n_s2.pr0[i] = mul_w(advect_x_q, it_s1.x[i]);
			n_s2.pr1[i] = mul_w(advect_y_q, it_s1.y[i]);
		end
	end

	// stage 3: rescale products
	always_comb begin
		trd_pkg::sat_t r;
		n_s3 = it_s2;
		for (int i = 0; i < 3; i++) begin
			r = fmul_w(it_s2.pr0[i]);
			n_s3.x[i] = r.w;
			n_s3.sat  = n_s3.sat | r.f;
			r = fmul_w(it_s2.pr1[i]);
			n_s3.y[i] = r.w;
			n_s3.sat  = n_s3.sat | r.f;
		end
	end

	// stage 4: k = half the dot product, split into parts
	always_comb begin
		trd_pkg::sat_t r;
		n_s4 = it_s3;
		for (int i = 0; i < 3; i++) begin
			r = trd_pkg::sat_w((ext(it_s3.x[i]) + ext(it_s3.y[i])) >>> 1);
			n_s4.x[i]  = r.w;
			n_s4.sat   = n_s4.sat | r.f;
			n_s4.kp[i] = ($signed(r.w) > 0) ? r.w : '0;
			n_s4.km[i] = r.w[W-1] ? r.w : '0;
		end
	end

	// stage 5: k * value, km * value, kpsum
	always_comb begin
		trd_pkg::sat_t r;
		n_s5 = it_s4;
		for (int i = 0; i < 3; i++) begin
			n_s5.pr0[i] = mul_w(it_s4.x[i], it_s4.v[i]);
			n_s5.pr1[i] = mul_w(it_s4.km[i], it_s4.v[i]);
		end
		r = trd_pkg::sat_w(ext(it_s4.kp[0]) + ext(it_s4.kp[1]) + ext(it_s4.kp[2]));
		n_s5.kpsum = r.w;
		n_s5.sat   = n_s5.sat | r.f;
	end

	// stage 6: residual fi, km * value terms, active check
	always_comb begin
		trd_pkg::sat_t r;
		logic signed [65:0] acc;
		n_s6 = it_s5;
		acc  = '0;
		for (int i = 0; i < 3; i++) begin
			r = fmul_w(it_s5.pr0[i]);
			acc      = acc + ext(r.w);
			n_s6.sat = n_s6.sat | r.f;
			r = fmul_w(it_s5.pr1[i]);
			n_s6.tm[i] = r.w;
			n_s6.sat   = n_s6.sat | r.f;
		end
		r = trd_pkg::sat_w(acc);
		n_s6.fi  = r.w;
		n_s6.sat = n_s6.sat | r.f;
		n_s6.act = (r.w != '0) && (it_s5.kpsum != '0);
	end

	// divider group a: km*v / kpsum and kp / kpsum
	for (genvar i = 0; i < 3; i++) begin : g_div_a
		trd_div #(.FRAC_BITS(FRAC_BITS)) u_div_s (
			.clk(clk), .en(en), .num(it_s6.tm[i]), .den(it_s6.kpsum),
			.quo(qs[i]), .ovf(os[i])
		);
		trd_div #(.FRAC_BITS(FRAC_BITS)) u_div_l (
			.clk(clk), .en(en), .num(it_s6.kp[i]), .den(it_s6.kpsum),
			.quo(ql[i]), .ovf(ol[i])
		);
	end

	// stage 7: sum s, lda * fi
	always_comb begin
		trd_pkg::sat_t r;
		item_t a;
		logic  m12;
		a    = dla_q[DIV_LAT-1];
		n_s7 = a;
		m12  = (a.mode == trd_pkg::SCH_LDA) || (a.mode == trd_pkg::SCH_BLEND);
		r = trd_pkg::sat_w(ext(qs[0]) + ext(qs[1]) + ext(qs[2]));
		n_s7.s   = r.w;
		n_s7.sat = a.sat | (a.act & (r.f | (|os))) | (a.act & m12 & (|ol));
		for (int i = 0; i < 3; i++) begin
			n_s7.lda[i] = ql[i];
			n_s7.pr0[i] = mul_w(ql[i], a.fi);
		end
	end

	// stage 8: v + s, lda share
	always_comb begin
		trd_pkg::sat_t r;
		logic m12;
		n_s8 = it_s7;
		m12  = (it_s7.mode == trd_pkg::SCH_LDA) || (it_s7.mode == trd_pkg::SCH_BLEND);
		for (int i = 0; i < 3; i++) begin
			r = trd_pkg::sat_w(ext(it_s7.v[i]) + ext(it_s7.s));
			n_s8.w[i] = r.w;
			n_s8.sat  = n_s8.sat | (it_s7.act & r.f);
			r = fmul_w(it_s7.pr0[i]);
			n_s8.lda[i] = r.w;
			n_s8.sat    = n_s8.sat | (it_s7.act & m12 & r.f);
		end
	end

	// stage 9: kp * (v + s)
	always_comb begin
		n_s9 = it_s8;
		for (int i = 0; i < 3; i++) begin
			n_s9.pr1[i] = mul_w(it_s8.kp[i], it_s8.w[i]);
		end
	end

	// stage 10: N shares
	always_comb begin
		trd_pkg::sat_t r;
		n_s10 = it_s9;
		for (int i = 0; i < 3; i++) begin
			r = fmul_w(it_s9.pr1[i]);
			n_s10.nsh[i] = r.w;
			n_s10.sat    = n_s10.sat | (it_s9.act & r.f);
		end
	end

	// stage 11: magnitudes for the blend weight
	always_comb begin
		trd_pkg::sat_t r;
		logic g;
		n_s11 = it_s10;
		g     = it_s10.act && (it_s10.mode == trd_pkg::SCH_BLEND);
		for (int i = 0; i < 3; i++) begin
			r = abs_w(it_s10.nsh[i]);
			n_s11.absn[i] = r.w;
			n_s11.sat     = n_s11.sat | (g & r.f);
		end
		r = abs_w(it_s10.fi);
		n_s11.absfi = r.w;
	end

	// stage 12: sum of N share magnitudes
	// |fi| only counts as saturated when the weight is actually divided out
	always_comb begin
		trd_pkg::sat_t r;
		n_s12 = it_s11;
		r = trd_pkg::sat_w(ext(it_s11.absn[0]) + ext(it_s11.absn[1]) + ext(it_s11.absn[2]));
		n_s12.acc = r.w;
		n_s12.sat = it_s11.sat |
			(it_s11.act && (it_s11.mode == trd_pkg::SCH_BLEND) &&
			(r.f || ((r.w != '0) && (it_s11.fi == trd_pkg::WORD_MIN))));
	end

	// divider group b: theta and beta
	trd_div #(.FRAC_BITS(FRAC_BITS)) u_div_t (
		.clk(clk), .en(en), .num(it_s12.absfi), .den(it_s12.acc),
		.quo(qt), .ovf(ot)
	);
	for (genvar i = 0; i < 3; i++) begin : g_div_b
		trd_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
			.clk(clk), .en(en), .num(it_s12.nsh[i]), .den(it_s12.fi),
			.quo(qb[i]), .ovf(ob[i])
		);
	end

	// stage 13: theta, clipped beta and its sum
	always_comb begin
		trd_pkg::sat_t r;
		item_t a;
		logic  g2, g3;
		a     = dlb_q[DIV_LAT-1];
		n_s13 = a;
		g2    = a.act && (a.mode == trd_pkg::SCH_BLEND);
		g3    = a.act && (a.mode == trd_pkg::SCH_LIMN);
		n_s13.theta = (a.acc != '0) ? qt : ONE_W;
		for (int i = 0; i < 3; i++) begin
			n_s13.bp[i] = ($signed(qb[i]) > 0) ? qb[i] : '0;
		end
		r = trd_pkg::sat_w(ext(n_s13.bp[0]) + ext(n_s13.bp[1]) + ext(n_s13.bp[2]));
		n_s13.bsum = r.w;
		n_s13.sat  = a.sat | (g2 & (a.acc != '0) & ot) | (g3 & ((|ob) | r.f));
	end

	// stage 14: 1 - theta, limiter denominator and numerators
	always_comb begin
		trd_pkg::sat_t r;
		logic g2, g3;
		n_s14 = it_s13;
		g2    = it_s13.act && (it_s13.mode == trd_pkg::SCH_BLEND);
		g3    = it_s13.act && (it_s13.mode == trd_pkg::SCH_LIMN);
		r = trd_pkg::sat_w(ext(ONE_W) - ext(it_s13.theta));
		n_s14.omt = r.w;
		n_s14.sat = n_s14.sat | (g2 & r.f);
		r = trd_pkg::sat_w(ext(it_s13.bsum) + 66'sd3);
		n_s14.accb = r.w;
		n_s14.sat  = n_s14.sat | (g3 & r.f);
		for (int i = 0; i < 3; i++) begin
			r = trd_pkg::sat_w(ext(it_s13.bp[i]) + 66'sd1);
			n_s14.nb[i] = r.w;
			n_s14.sat   = n_s14.sat | (g3 & r.f);
		end
	end

	// stage 15: blend or limiter products
	always_comb begin
		n_s15 = it_s14;
		for (int i = 0; i < 3; i++) begin
			n_s15.pr0[i] = (it_s14.mode == trd_pkg::SCH_LIMN) ?
				mul_w(it_s14.nb[i], it_s14.fi) : mul_w(it_s14.omt, it_s14.lda[i]);
			n_s15.pr1[i] = mul_w(it_s14.theta, it_s14.nsh[i]);
		end
	end

	// stage 16: rescale blend or limiter products
	always_comb begin
		trd_pkg::sat_t r;
		logic g2, g23;
		n_s16 = it_s15;
		g2    = it_s15.act && (it_s15.mode == trd_pkg::SCH_BLEND);
		g23   = it_s15.act &&
			((it_s15.mode == trd_pkg::SCH_BLEND) || (it_s15.mode == trd_pkg::SCH_LIMN));
		for (int i = 0; i < 3; i++) begin
			r = fmul_w(it_s15.pr0[i]);
			n_s16.f0[i] = r.w;
			n_s16.sat   = n_s16.sat | (g23 & r.f);
			r = fmul_w(it_s15.pr1[i]);
			n_s16.f1[i] = r.w;
			n_s16.sat   = n_s16.sat | (g2 & r.f);
		end
	end

	// stage 17: blended shares
	always_comb begin
		trd_pkg::sat_t r;
		logic g2;
		n_s17 = it_s16;
		g2    = it_s16.act && (it_s16.mode == trd_pkg::SCH_BLEND);
		for (int i = 0; i < 3; i++) begin
			r = trd_pkg::sat_w(ext(it_s16.f0[i]) + ext(it_s16.f1[i]));
			n_s17.d[i] = r.w;
			n_s17.sat  = n_s17.sat | (g2 & r.f);
		end
	end

	// divider group c: limited N shares
	for (genvar i = 0; i < 3; i++) begin : g_div_c
		trd_div #(.FRAC_BITS(FRAC_BITS)) u_div_c (
			.clk(clk), .en(en), .num(it_s17.f0[i]), .den(it_s17.accb),
			.quo(qc[i]), .ovf(oc[i])
		);
	end

	// stage 18: scheme select and zero residual or zero kpsum case
	always_comb begin
		item_t a;
		a         = dlc_q[DIV_LAT-1];
		n_s18.act = a.act;
		n_s18.sat = a.sat;
		case (a.mode)
			trd_pkg::SCH_N:     n_s18.d = a.nsh;
			trd_pkg::SCH_LDA:   n_s18.d = a.lda;
			trd_pkg::SCH_BLEND: n_s18.d = a.d;
			default: begin
				n_s18.d   = qc;
				n_s18.sat = a.sat | (a.act & (|oc));
			end
		endcase
		if (!a.act) begin
			n_s18.d = '0;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1  <= n_s1;
			it_s2  <= n_s2;
			it_s3  <= n_s3;
			it_s4  <= n_s4;
			it_s5  <= n_s5;
			it_s6  <= n_s6;
			dla_q[0] <= it_s6;
			for (int j = 1; j < DIV_LAT; j++) dla_q[j] <= dla_q[j-1];
			it_s7  <= n_s7;
			it_s8  <= n_s8;
			it_s9  <= n_s9;
			it_s10 <= n_s10;
			it_s11 <= n_s11;
			it_s12 <= n_s12;
			dlb_q[0] <= it_s12;
			for (int j = 1; j < DIV_LAT; j++) dlb_q[j] <= dlb_q[j-1];
			it_s13 <= n_s13;
			it_s14 <= n_s14;
			it_s15 <= n_s15;
			it_s16 <= n_s16;
			it_s17 <= n_s17;
			dlc_q[0] <= it_s17;
			for (int j = 1; j < DIV_LAT; j++) dlc_q[j] <= dlc_q[j-1];
			it_s18 <= n_s18;
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
			{v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18} <= '0;
			vla_q <= '0;
			vlb_q <= '0;
			vlc_q <= '0;
		end else if (en) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			vla_q <= {vla_q[DIV_LAT-2:0], v_s6};
			v_s7  <= vla_q[DIV_LAT-1];
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			vlb_q <= {vlb_q[DIV_LAT-2:0], v_s12};
			v_s13 <= vlb_q[DIV_LAT-1];
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			vlc_q <= {vlc_q[DIV_LAT-2:0], v_s17};
			v_s18 <= vlc_q[DIV_LAT-1];
		end
	end

	// output register and skid entry, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			out_v_q  <= skid_v_q | v_s18;
			skid_v_q <= 1'b0;
		end else if (v_s18 && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	// output register and skid entry, payload
	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : it_s18;
		end else if (v_s18 && !skid_v_q) begin
			skid_q <= it_s18;
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = out_q.d;
	assign m_tuser[0] = out_q.sat;

	// skid entry is only used behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid without output valid");

	// a taken output drains the skid entry
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && m_tready) |=> !skid_v_q)
		else $error("skid entry not drained");

	// zero residual or zero kpsum gives zero shares
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s18 && !it_s18.act) |-> (it_s18.d == '0))
		else $error("inactive triangle with nonzero shares");

endmodule

// File: bench/triangle_residual_distribution_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle residual distribution core testbench
// drives triangles through the stream port under four schemes and several
// advection settings, predicts the nodal shares in 64-bit fixed point and
// checks every returned request in order against the expected shares and flag
// ----------------------------------------------------------------------------
module triangle_residual_distribution_core_test;

	localparam int FRAC      = trd_pkg::FRAC_BITS_DEF;
	localparam longint ONE_Q = longint'(1) << FRAC;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 160;

	typedef struct {
		logic [95:0] shares;
		logic        satf;
	} share_set_t;

	typedef struct {
		trd_pkg::word_t f [9];
		bit    typed;
		logic [95:0] shares;
		logic        satf;
	} tri_row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_addr;
	logic [31:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	// vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, value0, value1, value2
	logic [287:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// share0, share1, share2
	logic [95:0]  m_tdata;
	// saturated
	logic [0:0]   m_tuser;

	triangle_residual_distribution_core dut (.*);

	// shadow of the configuration registers
	longint           vel_x, vel_y;
	trd_pkg::scheme_t scheme;
	bit               clamp_hit;

	share_set_t share_q [$];
	int          tx_idle, rx_idle;
	int          mismatches = 0;
	int          quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// fixed point helpers, each clamp raises the saturation flag
	function automatic longint clamp(input longint x);
		if (x > 64'sd2147483647) begin
			clamp_hit = 1'b1;
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			clamp_hit = 1'b1;
			return -64'sd2147483648;
		end
		return x;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return clamp((a * b) >>> FRAC);
	endfunction

	function automatic longint qdiv(input longint a, input longint b);
		return clamp((a * ONE_Q) / b);
	endfunction

	function automatic longint qabs(input longint a);
		return clamp(a < 0 ? -a : a);
	endfunction

	// nodal shares of one triangle under the current scheme
	function automatic share_set_t distribute(input trd_pkg::word_t f [9]);
		share_set_t r;
		longint px[3], py[3], v[3], k[3], kp[3], km[3], nsh[3], d[3], bp[3];
		longint kpsum, fi, s, acc, theta, omt, nx, ny, lda, beta;
		int a, b;
		clamp_hit = 1'b0;
		kpsum = 0;
		fi = 0;
		for (int i = 0; i < 3; i++) begin
			px[i] = longint'($signed(f[2*i]));
			py[i] = longint'($signed(f[2*i+1]));
			v[i]  = longint'($signed(f[6+i]));
			d[i]  = 0;
		end
		// inward edge normals and upwind parameters
		for (int i = 0; i < 3; i++) begin
			a = (i + 2) % 3;
			b = (i + 1) % 3;
			nx = clamp(py[b] - py[a]);
			ny = clamp(px[a] - px[b]);
			k[i] = clamp((qmul(vel_x, nx) + qmul(vel_y, ny)) >>> 1);
			kp[i] = k[i] > 0 ? k[i] : 0;
			km[i] = k[i] < 0 ? k[i] : 0;
			kpsum += kp[i];
			fi += qmul(k[i], v[i]);
		end
		kpsum = clamp(kpsum);
		fi = clamp(fi);
		if (fi != 0 && kpsum != 0) begin
			s = 0;
			for (int i = 0; i < 3; i++) s += qdiv(qmul(km[i], v[i]), kpsum);
			s = clamp(s);
			for (int i = 0; i < 3; i++) nsh[i] = qmul(kp[i], clamp(v[i] + s));
			case (scheme)
				trd_pkg::SCH_N: begin
					for (int i = 0; i < 3; i++) d[i] = nsh[i];
				end
				trd_pkg::SCH_LDA: begin
					for (int i = 0; i < 3; i++) d[i] = qmul(qdiv(kp[i], kpsum), fi);
				end
				trd_pkg::SCH_BLEND: begin
					acc = 0;
					for (int i = 0; i < 3; i++) acc += qabs(nsh[i]);
					acc = clamp(acc);
					theta = acc != 0 ? qdiv(qabs(fi), acc) : ONE_Q;
					omt = clamp(ONE_Q - theta);
					for (int i = 0; i < 3; i++) begin
						lda = qmul(qdiv(kp[i], kpsum), fi);
						d[i] = clamp(qmul(omt, lda) + qmul(theta, nsh[i]));
					end
				end
				default: begin
					acc = 0;
					for (int i = 0; i < 3; i++) begin
						beta = qdiv(nsh[i], fi);
						bp[i] = beta > 0 ? beta : 0;
						acc += bp[i];
					end
					acc = clamp(clamp(acc) + 3);
					for (int i = 0; i < 3; i++) d[i] = qdiv(qmul(clamp(bp[i] + 1), fi), acc);
				end
			endcase
		end
		for (int i = 0; i < 3; i++) r.shares[32*i +: 32] = d[i][31:0];
		r.satf = clamp_hit;
		return r;
	endfunction

	// register write, shadow follows
	task automatic write_reg(input logic [1:0] idx, input trd_pkg::word_t val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			trd_pkg::REG_ADVECT_X: vel_x = longint'($signed(val));
			trd_pkg::REG_ADVECT_Y: vel_y = longint'($signed(val));
			default:               scheme = trd_pkg::scheme_t'(val[1:0]);
		endcase
	endtask

	task automatic set_config(input trd_pkg::word_t ax, input trd_pkg::word_t ay,
		input trd_pkg::scheme_t m);
		write_reg(trd_pkg::REG_ADVECT_X, ax);
		write_reg(trd_pkg::REG_ADVECT_Y, ay);
		write_reg(trd_pkg::REG_SCHEME, trd_pkg::word_t'(m));
	endtask

	// present one triangle and hold it until taken
	task automatic send_triangle(input tri_row_t row);
		logic [287:0] packed_in;
		share_set_t   exp_set;
		for (int i = 0; i < 9; i++) packed_in[32*i +: 32] = row.f[i];
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= packed_in;
		do @(posedge clk); while (!s_tready);
		exp_set = distribute(row.f);
		if (row.typed) begin
			exp_set.shares = row.shares;
			exp_set.satf   = row.satf;
		end
		share_q.push_back(exp_set);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (share_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic trd_pkg::word_t pick_word(input int span);
		case ($urandom_range(9))
			0: return $urandom;
			1: case ($urandom_range(4))
				0: return trd_pkg::WORD_MAX;
				1: return trd_pkg::WORD_MIN;
				2: return 32'h0;
				3: return 32'h1;
				default: return 32'hffff_ffff;
			endcase
			default: return trd_pkg::word_t'($urandom_range(2 * span) - span);
		endcase
	endfunction

	function automatic tri_row_t random_row();
		tri_row_t r;
		r.typed = 1'b0;
		for (int i = 0; i < 9; i++) r.f[i] = pick_word(i < 6 ? (8 << FRAC) : (4 << FRAC));
		return r;
	endfunction

	function automatic tri_row_t make_row(input trd_pkg::word_t x0, y0, x1, y1, x2, y2,
		u0, u1, u2);
		tri_row_t r;
		r.f = '{x0, y0, x1, y1, x2, y2, u0, u1, u2};
		r.typed = 1'b0;
		r.shares = '0;
		r.satf = 1'b0;
		return r;
	endfunction

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// result check and stall watchdog
	always @(posedge clk) begin
		share_set_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (share_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected request shares=%h sat=%b", m_tdata, m_tuser);
				end else begin
					want = share_q.pop_front();
					for (int i = 0; i < 3; i++) begin
						if (m_tdata[32*i +: 32] !== want.shares[32*i +: 32]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("share%0d exp %h got %h", i,
									want.shares[32*i +: 32], m_tdata[32*i +: 32]);
						end
					end
					if (m_tuser[0] !== want.satf) begin
						mismatches++;
						if (mismatches <= 10)
							$display("saturated exp %b got %b", want.satf, m_tuser[0]);
					end
				end
			end
		end
	end

	initial begin
		tri_row_t rows [$];
		tri_row_t r;
		trd_pkg::word_t ax, ay;
		tx_idle = 0;
		rx_idle = 0;
		vel_x = 0;
		vel_y = 0;
		scheme = trd_pkg::SCH_N;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero advection after reset: every share is zero
		r = make_row(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0002_0000, 32'h0001_0000, 1);
		r.typed = 1'b1;
		rows.push_back(r);
		r = make_row(trd_pkg::WORD_MAX, trd_pkg::WORD_MIN, trd_pkg::WORD_MIN,
			trd_pkg::WORD_MAX, 0, 0, trd_pkg::WORD_MAX, trd_pkg::WORD_MIN, 1);
		r.typed = 1'b1;
		r.satf = 1'b1;
		rows.push_back(r);
		foreach (rows[i]) send_triangle(rows[i]);
		wait_drained();

		// directed triangles under every scheme
		rows.delete();
		rows.push_back(make_row(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000,
			32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
		rows.push_back(make_row(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		rows.push_back(make_row(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000,
			32'hffff_0000, 32'h0003_0000, 32'hfffe_8000));
		rows.push_back(make_row(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000,
			trd_pkg::WORD_MAX, trd_pkg::WORD_MIN, 32'h0001_0000));
		rows.push_back(make_row(trd_pkg::WORD_MIN, trd_pkg::WORD_MIN, trd_pkg::WORD_MAX,
			trd_pkg::WORD_MIN, trd_pkg::WORD_MIN, trd_pkg::WORD_MAX,
			32'h0001_0000, 32'h0004_0000, 32'hfffc_0000));
		for (int m = 0; m < 4; m++) begin
			set_config(32'h0001_0000, 32'h0000_8000, trd_pkg::scheme_t'(m));
			foreach (rows[i]) send_triangle(rows[i]);
			wait_drained();
		end
		set_config(trd_pkg::WORD_MAX, trd_pkg::WORD_MIN, trd_pkg::SCH_BLEND);
		foreach (rows[i]) send_triangle(rows[i]);
		wait_drained();

		// random triangles across idling patterns and settings
		for (int p = 0; p < 3; p++) begin
			tx_idle = (p == 0) ? 16 : (p == 1) ? 71 : 0;
			rx_idle = (p == 0) ? 71 : (p == 1) ? 16 : 0;
			for (int m = 0; m < 4; m++) begin
				ax = ($urandom_range(5) == 0) ? pick_word(0) :
					trd_pkg::word_t'($urandom_range(4 << FRAC) - (2 << FRAC));
				ay = ($urandom_range(5) == 0) ? pick_word(0) :
					trd_pkg::word_t'($urandom_range(4 << FRAC) - (2 << FRAC));
				set_config(ax, ay, trd_pkg::scheme_t'(m));
				repeat (90) send_triangle(random_row());
				wait_drained();
			end
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
